// File: rtl/scsp_pkg.sv
`timescale 1ns / 1ps

package scsp_pkg;

   // Register indexes of the configuration port.
   localparam logic [2:0] CSR_ANGLE_START = 3'd0;
   localparam logic [2:0] CSR_ANGLE_STEP  = 3'd1;
   localparam logic [2:0] CSR_GAP_LIMIT   = 3'd2;
   localparam logic [2:0] CSR_NEAR_BAND   = 3'd3;
   localparam logic [2:0] CSR_FAR_BAND    = 3'd4;
   localparam logic [2:0] CSR_MIN_SPAN    = 3'd5;

   // Register reset values.
   localparam logic [15:0] RST_ANGLE_START = 16'h8000;
   localparam logic [11:0] RST_ANGLE_STEP  = 12'd182;
   localparam logic [15:0] RST_GAP_LIMIT   = 16'd100;
   localparam logic [15:0] RST_NEAR_BAND   = 16'd5000;
   localparam logic [15:0] RST_FAR_BAND    = 16'd10000;
   localparam logic [15:0] RST_MIN_SPAN    = 16'd250;

   // Classification limits per range band.
   localparam logic [31:0] NEAR_MIN_PTS = 32'd15;
   localparam logic [31:0] NEAR_MAX_PTS = 32'd70;
   localparam logic [31:0] MID_MIN_PTS  = 32'd10;
   localparam logic [31:0] MID_MAX_PTS  = 32'd35;
   localparam logic [31:0] FAR_MIN_PTS  = 32'd5;
   localparam logic [31:0] FAR_MAX_PTS  = 32'd18;
   localparam logic [36:0] NEAR_MAX_L2  = 37'd490000;
   localparam logic [36:0] MID_MAX_L2   = 37'd422500;
   localparam logic [36:0] FAR_MAX_L2   = 37'd490000;

   // Quarter turn in angle units.
   localparam logic [15:0] QUARTER_TURN = 16'h4000;

   typedef enum logic [4:0] {
      ST_LOAD,
      ST_IDLE,
      ST_ADDR_C,
      ST_ADDR_S,
      ST_MUL_X,
      ST_MUL_Y,
      ST_MUL_DX,
      ST_MUL_DY,
      ST_GAP,
      ST_DECIDE,
      ST_UPDATE,
      ST_CHECK_EOS,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_MUL_WX,
      ST_MUL_WY,
      ST_MUL_W2,
      ST_MUL_SPAN,
      ST_EMIT,
      ST_FINISH
   } scsp_state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_ACCEPT,
      OP_ADDR_C,
      OP_ADDR_S,
      OP_MUL_X,
      OP_MUL_Y,
      OP_MUL_DX,
      OP_MUL_DY,
      OP_GAP,
      OP_UPDATE,
      OP_DIV_START,
      OP_MUL_WX,
      OP_MUL_WY,
      OP_MUL_W2,
      OP_MUL_SPAN,
      OP_EMIT,
      OP_FINISH
   } scsp_op_type;

   typedef struct packed {
      scsp_op_type op;
      logic        emit_last;
   } scsp_cmd_type;

   typedef struct packed {
      logic load_done;
      logic beam_valid;
      logic beam_eos;
      logic open;
      logic split;
      logic div_busy;
      logic slot_free;
   } scsp_status_type;

endpackage

// File: rtl/scsp_req_if.sv
`timescale 1ns / 1ps

interface scsp_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] range_mm;
   logic        range_valid;
   logic        end_of_scan;

   modport source (output valid, output range_mm, output range_valid, output end_of_scan,
                   input ready);
   modport sink (input valid, input range_mm, input range_valid, input end_of_scan,
                 output ready);
endinterface

// File: rtl/scsp_rsp_if.sv
`timescale 1ns / 1ps

interface scsp_rsp_if;
   logic               valid;
   logic               ready;
   logic [11:0]        cluster_number;
   logic [11:0]        cluster_points;
   logic signed [16:0] box_min_x;
   logic signed [16:0] box_min_y;
   logic signed [16:0] box_max_x;
   logic signed [16:0] box_max_y;
   logic [15:0]        mean_range_mm;
   logic               is_person;
   logic               scan_last;

   modport source (output valid, output cluster_number, output cluster_points,
                   output box_min_x, output box_min_y, output box_max_x, output box_max_y,
                   output mean_range_mm, output is_person, output scan_last, input ready);
   modport sink (input valid, input cluster_number, input cluster_points,
                 input box_min_x, input box_min_y, input box_max_x, input box_max_y,
                 input mean_range_mm, input is_person, input scan_last, output ready);
endinterface

// File: rtl/scsp_ram.sv
`timescale 1ns / 1ps

module scsp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1025
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port, one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/scsp_div.sv
`timescale 1ns / 1ps

module scsp_div #(
   parameter int TW = 28,
   parameter int CB = 12
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [TW-1:0] dividend,
   input  logic [CB-1:0] divisor,
   output logic          busy,
   output logic [TW-1:0] quotient
);

   localparam int CW = $clog2(TW + 1);

   logic [TW-1:0] quo_ff, quo_in;
   logic [CB-1:0] rem_ff, rem_in;
   logic [CB-1:0] dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CB:0]   trial;

   // Restoring division, one quotient bit per cycle.
   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      trial  = {rem_ff, quo_ff[TW-1]};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CW'(TW);
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = CB'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[TW-2:0], 1'b1};
         end else begin
            rem_in = trial[CB-1:0];
            quo_in = {quo_ff[TW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = (cnt_ff != '0);
   assign quotient = quo_ff;

endmodule

// File: rtl/scsp_datapath.sv
`timescale 1ns / 1ps

module scsp_datapath #(
   parameter int COUNT_BITS = 12,
   parameter int RANGE_BITS = 16,
   parameter int SINE_DEPTH = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [2:0]                csr_index,
   input  logic [15:0]               csr_wdata,
   input  logic [15:0]               beat_range_mm,
   input  logic                      beat_range_valid,
   input  logic                      beat_end_of_scan,
   input  scsp_pkg::scsp_cmd_type    cmd,
   output scsp_pkg::scsp_status_type status,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [11:0]               out_cluster_number,
   output logic [11:0]               out_cluster_points,
   output logic signed [16:0]        out_box_min_x,
   output logic signed [16:0]        out_box_min_y,
   output logic signed [16:0]        out_box_max_x,
   output logic signed [16:0]        out_box_max_y,
   output logic [15:0]               out_mean_range_mm,
   output logic                      out_is_person,
   output logic                      out_scan_last
);

   localparam int RW   = (RANGE_BITS < 16) ? RANGE_BITS : 16;
   localparam int TW   = RW + COUNT_BITS;
   localparam int AW   = $clog2(SINE_DEPTH + 1);
   localparam int FW   = $clog2(SINE_DEPTH + 2);
   localparam logic [COUNT_BITS-1:0] CMAX = '1;

   typedef logic [15:0] lut_type [SINE_DEPTH + 1];

   // Quarter-wave sine table by a truncated Taylor series in Q30.
   function automatic lut_type build_lut();
      lut_type            t;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        v;
      logic signed [63:0] sum;
      for (int k = 0; k <= SINE_DEPTH; k++) begin
         x    = (64'(k) * 64'd1686629713) / 64'(SINE_DEPTH);
         x2   = (x * x) >> 30;
         term = x;
         sum  = $signed(x);
         for (int n = 1; n <= 7; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
               sum = sum - $signed(term);
            end else begin
               sum = sum + $signed(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         v = ($unsigned(sum) * 64'd65535 + 64'd536870912) >> 30;
         t[k] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
      end
      return t;
   endfunction

   localparam lut_type SINE_LUT = build_lut();

   // Table index of an angle; odd quadrants read the table backwards.
   function automatic logic [AW-1:0] sine_index(input logic [15:0] a);
      logic [31:0] prod;
      logic [31:0] idx;
      prod = 32'(a[13:0]) * 32'(SINE_DEPTH);
      idx  = prod >> 14;
      if (a[14]) begin
         idx = 32'(SINE_DEPTH) - idx;
      end
      return AW'(idx);
   endfunction

   // Configuration registers.
   logic [15:0] angle_start_ff;
   logic [11:0] angle_step_ff;
   logic [15:0] gap_ff;
   logic [15:0] near_ff;
   logic [15:0] far_ff;
   logic [15:0] span_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_start_ff <= scsp_pkg::RST_ANGLE_START;
         angle_step_ff  <= scsp_pkg::RST_ANGLE_STEP;
         gap_ff         <= scsp_pkg::RST_GAP_LIMIT;
         near_ff        <= scsp_pkg::RST_NEAR_BAND;
         far_ff         <= scsp_pkg::RST_FAR_BAND;
         span_ff        <= scsp_pkg::RST_MIN_SPAN;
      end else if (csr_we) begin
         unique case (csr_index)
            scsp_pkg::CSR_ANGLE_START: angle_start_ff <= csr_wdata;
            scsp_pkg::CSR_ANGLE_STEP:  angle_step_ff  <= csr_wdata[11:0];
            scsp_pkg::CSR_GAP_LIMIT:   gap_ff         <= csr_wdata;
            scsp_pkg::CSR_NEAR_BAND:   near_ff        <= csr_wdata;
            scsp_pkg::CSR_FAR_BAND:    far_ff         <= csr_wdata;
            scsp_pkg::CSR_MIN_SPAN:    span_ff        <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Sine table memory and its load sweep after reset.
   logic [FW-1:0] fill_ff;
   logic          load_done;
   logic          ram_we;
   logic [AW-1:0] ram_raddr;
   logic [15:0]   ram_rdata;

   assign load_done = (fill_ff == FW'(SINE_DEPTH + 1));
   assign ram_we    = (cmd.op == scsp_pkg::OP_LOAD) && !load_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (ram_we) begin
         fill_ff <= fill_ff + FW'(1);
      end
   end

   scsp_ram #(
      .WIDTH (16),
      .DEPTH (SINE_DEPTH + 1)
   ) u_sine_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (fill_ff[AW-1:0]),
      .wdata (SINE_LUT[fill_ff[AW-1:0]]),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Beat and per-beam working registers.
   logic [RW-1:0]      r_ff;
   logic               bvalid_ff;
   logic               beos_ff;
   logic [15:0]        angle_ff;
   logic [15:0]        beam_ff;
   logic               fresh_ff;
   logic               cneg_ff, sneg_ff;
   logic [15:0]        cmag_ff, smag_ff;
   logic signed [16:0] x_ff, y_ff;
   logic signed [16:0] last_x_ff, last_y_ff;
   logic [36:0]        acc_ff;
   logic               split_ff;
   logic [17:0]        w_ff;
   logic [35:0]        w2_ff;
   logic [39:0]        nine_ff;
   logic [31:0]        span2_ff;
   logic [RW-1:0]      mean_ff;

   // Cluster state.
   logic                  open_ff;
   logic [COUNT_BITS-1:0] pt_ff;
   logic [TW-1:0]         total_ff;
   logic signed [16:0]    lo_x_ff, lo_y_ff, hi_x_ff, hi_y_ff;
   logic [COUNT_BITS-1:0] ctally_ff;

   // Output register.
   logic                  ovalid_ff, ovalid_in;
   logic [11:0]           onum_ff, opts_ff;
   logic signed [16:0]    omin_x_ff, omin_y_ff, omax_x_ff, omax_y_ff;
   logic [15:0]           omean_ff;
   logic                  operson_ff, olast_ff;

   logic slot_free;
   assign slot_free = !ovalid_ff || out_ready;

   // The response stays valid until taken, and a new cluster fills the slot.
   always_comb begin
      ovalid_in = ovalid_ff && !out_ready;
      if (cmd.op == scsp_pkg::OP_EMIT) begin
         ovalid_in = 1'b1;
      end
   end

   // Shared multiplier with operand selection per step.
   logic signed [17:0] dx, dy, wx, wy;
   logic [17:0]        mul_a, mul_b;
   logic [35:0]        prod;
   logic [16:0]        round_v;
   logic signed [16:0] scaled;

   assign dx = 18'(x_ff) - 18'(last_x_ff);
   assign dy = 18'(y_ff) - 18'(last_y_ff);
   assign wx = 18'(hi_x_ff) - 18'(lo_x_ff);
   assign wy = 18'(hi_y_ff) - 18'(lo_y_ff);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         scsp_pkg::OP_MUL_X: begin
            mul_a = 18'(r_ff);
            mul_b = 18'(cmag_ff);
         end
         scsp_pkg::OP_MUL_Y: begin
            mul_a = 18'(r_ff);
            mul_b = 18'(smag_ff);
         end
         scsp_pkg::OP_MUL_DX: begin
            mul_a = dx[17] ? 18'(-dx) : 18'(dx);
            mul_b = mul_a;
         end
         scsp_pkg::OP_MUL_DY: begin
            mul_a = dy[17] ? 18'(-dy) : 18'(dy);
            mul_b = mul_a;
         end
         scsp_pkg::OP_GAP: begin
            mul_a = 18'(gap_ff);
            mul_b = 18'(gap_ff);
         end
         scsp_pkg::OP_MUL_WX: begin
            mul_a = 18'(wx);
            mul_b = 18'(wx);
         end
         scsp_pkg::OP_MUL_WY: begin
            mul_a = 18'(wy);
            mul_b = 18'(wy);
         end
         scsp_pkg::OP_MUL_W2: begin
            mul_a = w_ff;
            mul_b = w_ff;
         end
         scsp_pkg::OP_MUL_SPAN: begin
            mul_a = 18'(span_ff);
            mul_b = 18'(span_ff);
         end
         default: ;
      endcase
   end

   assign prod    = mul_a * mul_b;
   assign round_v = 17'((prod[32:0] + 33'd32768) >> 16);

   // Sign of the coordinate follows the sign of the sine or cosine.
   always_comb begin
      if (((cmd.op == scsp_pkg::OP_MUL_X) && cneg_ff) ||
          ((cmd.op == scsp_pkg::OP_MUL_Y) && sneg_ff)) begin
         scaled = -$signed(round_v);
      end else begin
         scaled = $signed(round_v);
      end
   end

   // Divider for the mean range.
   logic [TW-1:0] quotient;
   logic          div_busy;

   scsp_div #(
      .TW (TW),
      .CB (COUNT_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == scsp_pkg::OP_DIV_START),
      .dividend (total_ff),
      .divisor  (pt_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // Sine memory read address per step.
   logic [15:0] cos_angle;
   assign cos_angle = angle_ff + scsp_pkg::QUARTER_TURN;

   always_comb begin
      if (cmd.op == scsp_pkg::OP_ADDR_C) begin
         ram_raddr = sine_index(cos_angle);
      end else begin
         ram_raddr = sine_index(angle_ff);
      end
   end

   // Person classification from the registered box measures.
   logic [31:0] cnt32;
   logic [15:0] mean16;
   logic        shape_ok, near_ok, mid_ok, far_ok, person;

   assign cnt32  = 32'(pt_ff);
   assign mean16 = 16'(mean_ff);

   always_comb begin
      shape_ok = (w_ff != '0) && ({3'b000, acc_ff} <= nine_ff) &&
                 (acc_ff >= 37'(span2_ff));
      near_ok  = (mean16 <= near_ff) && (cnt32 >= scsp_pkg::NEAR_MIN_PTS) &&
                 (cnt32 <= scsp_pkg::NEAR_MAX_PTS) && (acc_ff <= scsp_pkg::NEAR_MAX_L2);
      mid_ok   = (mean16 > near_ff) && (mean16 <= far_ff) &&
                 (cnt32 >= scsp_pkg::MID_MIN_PTS) && (cnt32 <= scsp_pkg::MID_MAX_PTS) &&
                 (acc_ff <= scsp_pkg::MID_MAX_L2);
      far_ok   = (mean16 > far_ff) && (cnt32 >= scsp_pkg::FAR_MIN_PTS) &&
                 (cnt32 <= scsp_pkg::FAR_MAX_PTS) && (acc_ff <= scsp_pkg::FAR_MAX_L2);
      person   = shape_ok && (near_ok || mid_ok || far_ok);
   end

   // Control registers of the datapath.
   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff  <= 1'b1;
         beam_ff   <= '0;
         open_ff   <= 1'b0;
         ctally_ff <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         ovalid_ff <= ovalid_in;
         case (cmd.op)
            scsp_pkg::OP_ACCEPT: begin
               fresh_ff <= 1'b0;
               beam_ff  <= (fresh_ff ? angle_start_ff : beam_ff) + 16'(angle_step_ff);
            end
            scsp_pkg::OP_UPDATE: begin
               open_ff <= 1'b1;
            end
            scsp_pkg::OP_EMIT: begin
               open_ff   <= 1'b0;
               if (ctally_ff != CMAX) begin
                  ctally_ff <= ctally_ff + COUNT_BITS'(1);
               end
            end
            scsp_pkg::OP_FINISH: begin
               open_ff   <= 1'b0;
               ctally_ff <= '0;
               fresh_ff  <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   // Payload registers, stepped by the command.
   always_ff @(posedge clock) begin
      case (cmd.op)
         scsp_pkg::OP_ACCEPT: begin
            r_ff      <= beat_range_mm[RW-1:0];
            bvalid_ff <= beat_range_valid;
            beos_ff   <= beat_end_of_scan;
            angle_ff  <= fresh_ff ? angle_start_ff : beam_ff;
         end
         scsp_pkg::OP_ADDR_S: begin
            cmag_ff <= ram_rdata;
            cneg_ff <= cos_angle[15];
         end
         scsp_pkg::OP_MUL_X: begin
            smag_ff <= ram_rdata;
            sneg_ff <= angle_ff[15];
            x_ff    <= scaled;
         end
         scsp_pkg::OP_MUL_Y: begin
            y_ff <= scaled;
         end
         scsp_pkg::OP_MUL_DX: begin
            acc_ff <= 37'(prod);
         end
         scsp_pkg::OP_MUL_DY: begin
            acc_ff <= acc_ff + 37'(prod);
         end
         scsp_pkg::OP_GAP: begin
            split_ff <= open_ff && (acc_ff >= 37'(prod));
         end
         scsp_pkg::OP_UPDATE: begin
            last_x_ff <= x_ff;
            last_y_ff <= y_ff;
            if (open_ff) begin
               if (pt_ff != CMAX) begin
                  pt_ff    <= pt_ff + COUNT_BITS'(1);
                  total_ff <= total_ff + TW'(r_ff);
               end
               if (x_ff < lo_x_ff) lo_x_ff <= x_ff;
               if (x_ff > hi_x_ff) hi_x_ff <= x_ff;
               if (y_ff < lo_y_ff) lo_y_ff <= y_ff;
               if (y_ff > hi_y_ff) hi_y_ff <= y_ff;
            end else begin
               pt_ff    <= COUNT_BITS'(1);
               total_ff <= TW'(r_ff);
               lo_x_ff  <= x_ff;
               hi_x_ff  <= x_ff;
               lo_y_ff  <= y_ff;
               hi_y_ff  <= y_ff;
            end
         end
         scsp_pkg::OP_MUL_WX: begin
            acc_ff  <= 37'(prod);
            w_ff    <= (wx < wy) ? 18'(wx) : 18'(wy);
            mean_ff <= quotient[RW-1:0];
         end
         scsp_pkg::OP_MUL_WY: begin
            acc_ff <= acc_ff + 37'(prod);
         end
         scsp_pkg::OP_MUL_W2: begin
            w2_ff <= prod;
         end
         scsp_pkg::OP_MUL_SPAN: begin
            span2_ff <= prod[31:0];
            nine_ff  <= {w2_ff, 3'b000} + 40'(w2_ff);
         end
         scsp_pkg::OP_EMIT: begin
            onum_ff    <= 12'(ctally_ff);
            opts_ff    <= 12'(pt_ff);
            omin_x_ff  <= lo_x_ff;
            omin_y_ff  <= lo_y_ff;
            omax_x_ff  <= hi_x_ff;
            omax_y_ff  <= hi_y_ff;
            omean_ff   <= mean16;
            operson_ff <= person;
            olast_ff   <= cmd.emit_last;
         end
         default: ;
      endcase
   end

   assign status.load_done  = load_done;
   assign status.beam_valid = bvalid_ff;
   assign status.beam_eos   = beos_ff;
   assign status.open       = open_ff;
   assign status.split      = split_ff;
   assign status.div_busy   = div_busy;
   assign status.slot_free  = slot_free;

   assign out_valid          = ovalid_ff;
   assign out_cluster_number = onum_ff;
   assign out_cluster_points = opts_ff;
   assign out_box_min_x      = omin_x_ff;
   assign out_box_min_y      = omin_y_ff;
   assign out_box_max_x      = omax_x_ff;
   assign out_box_max_y      = omax_y_ff;
   assign out_mean_range_mm  = omean_ff;
   assign out_is_person      = operson_ff;
   assign out_scan_last      = olast_ff;

endmodule

// File: rtl/scsp_ctrl.sv
`timescale 1ns / 1ps

module scsp_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      beat_valid,
   output logic                      beat_ready,
   input  scsp_pkg::scsp_status_type status,
   output scsp_pkg::scsp_cmd_type    cmd
);

   scsp_pkg::scsp_state_type state_ff, state_in;
   logic                     last_ff, last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scsp_pkg::ST_LOAD;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
      end
   end

   // Next state and the command for the datapath.
   always_comb begin
      state_in      = state_ff;
      last_in       = last_ff;
      beat_ready    = 1'b0;
      cmd.op        = scsp_pkg::OP_NONE;
      cmd.emit_last = last_ff;
      unique case (state_ff)
         scsp_pkg::ST_LOAD: begin
            cmd.op = scsp_pkg::OP_LOAD;
            if (status.load_done) state_in = scsp_pkg::ST_IDLE;
         end
         scsp_pkg::ST_IDLE: begin
            beat_ready = 1'b1;
            if (beat_valid) begin
               cmd.op   = scsp_pkg::OP_ACCEPT;
               state_in = scsp_pkg::ST_ADDR_C;
            end
         end
         scsp_pkg::ST_ADDR_C: begin
            if (status.beam_valid) begin
               cmd.op   = scsp_pkg::OP_ADDR_C;
               state_in = scsp_pkg::ST_ADDR_S;
            end else begin
               state_in = scsp_pkg::ST_CHECK_EOS;
            end
         end
         scsp_pkg::ST_ADDR_S: begin
            cmd.op   = scsp_pkg::OP_ADDR_S;
            state_in = scsp_pkg::ST_MUL_X;
         end
         scsp_pkg::ST_MUL_X: begin
            cmd.op   = scsp_pkg::OP_MUL_X;
            state_in = scsp_pkg::ST_MUL_Y;
         end
         scsp_pkg::ST_MUL_Y: begin
            cmd.op   = scsp_pkg::OP_MUL_Y;
            state_in = scsp_pkg::ST_MUL_DX;
         end
         scsp_pkg::ST_MUL_DX: begin
            cmd.op   = scsp_pkg::OP_MUL_DX;
            state_in = scsp_pkg::ST_MUL_DY;
         end
         scsp_pkg::ST_MUL_DY: begin
            cmd.op   = scsp_pkg::OP_MUL_DY;
            state_in = scsp_pkg::ST_GAP;
         end
         scsp_pkg::ST_GAP: begin
            cmd.op   = scsp_pkg::OP_GAP;
            state_in = scsp_pkg::ST_DECIDE;
         end
         scsp_pkg::ST_DECIDE: begin
            if (status.split) begin
               last_in  = 1'b0;
               state_in = scsp_pkg::ST_DIV_START;
            end else begin
               state_in = scsp_pkg::ST_UPDATE;
            end
         end
         scsp_pkg::ST_UPDATE: begin
            cmd.op   = scsp_pkg::OP_UPDATE;
            state_in = scsp_pkg::ST_CHECK_EOS;
         end
         scsp_pkg::ST_CHECK_EOS: begin
            if (!status.beam_eos) begin
               state_in = scsp_pkg::ST_IDLE;
            end else if (status.open) begin
               last_in  = 1'b1;
               state_in = scsp_pkg::ST_DIV_START;
            end else begin
               state_in = scsp_pkg::ST_FINISH;
            end
         end
         scsp_pkg::ST_DIV_START: begin
            cmd.op   = scsp_pkg::OP_DIV_START;
            state_in = scsp_pkg::ST_DIV_WAIT;
         end
         scsp_pkg::ST_DIV_WAIT: begin
            if (!status.div_busy) state_in = scsp_pkg::ST_MUL_WX;
         end
         scsp_pkg::ST_MUL_WX: begin
            cmd.op   = scsp_pkg::OP_MUL_WX;
            state_in = scsp_pkg::ST_MUL_WY;
         end
         scsp_pkg::ST_MUL_WY: begin
            cmd.op   = scsp_pkg::OP_MUL_WY;
            state_in = scsp_pkg::ST_MUL_W2;
         end
         scsp_pkg::ST_MUL_W2: begin
            cmd.op   = scsp_pkg::OP_MUL_W2;
            state_in = scsp_pkg::ST_MUL_SPAN;
         end
         scsp_pkg::ST_MUL_SPAN: begin
            cmd.op   = scsp_pkg::OP_MUL_SPAN;
            state_in = scsp_pkg::ST_EMIT;
         end
         scsp_pkg::ST_EMIT: begin
            // Wait for the output register to free up.
            if (status.slot_free) begin
               cmd.op   = scsp_pkg::OP_EMIT;
               state_in = last_ff ? scsp_pkg::ST_FINISH : scsp_pkg::ST_UPDATE;
            end
         end
         scsp_pkg::ST_FINISH: begin
            cmd.op   = scsp_pkg::OP_FINISH;
            state_in = scsp_pkg::ST_IDLE;
         end
         default: begin
            state_in = scsp_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/scan_segment_person_classifier_unit.sv
`timescale 1ns / 1ps
// Channel   Ports         Direction  Beat
// request   req_chan      in         one range sample with validity and end-of-scan marks
// response  rsp_chan      out        one closed cluster with box, mean and person flag
// config    csr_*         in         register write, index and data, no read-back
//
// A valid beam passes through the shared multiplier and the sine memory port. Each
// emitted cluster adds a run of the bit-serial mean divider over RW+COUNT_BITS bits,
// RW being RANGE_BITS capped at 16; an end of scan adds the finish state. After reset
// all SINE_DEPTH+1 entries of the sine table memory are loaded before the first beat
// is taken.
// The response sits in an output register; a stalled response holds the block only
// when a further cluster must be emitted.

module scan_segment_person_classifier_unit #(
   parameter int COUNT_BITS = 12,
   parameter int RANGE_BITS = 16,
   parameter int SINE_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   scsp_req_if.sink    req_chan,
   scsp_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   scsp_pkg::scsp_cmd_type    cmd;
   scsp_pkg::scsp_status_type status;
   logic                      ready;

   scsp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (req_chan.valid),
      .beat_ready (ready),
      .status     (status),
      .cmd        (cmd)
   );

   assign req_chan.ready = ready;

   scsp_datapath #(
      .COUNT_BITS (COUNT_BITS),
      .RANGE_BITS (RANGE_BITS),
      .SINE_DEPTH (SINE_DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .beat_range_mm      (req_chan.range_mm),
      .beat_range_valid   (req_chan.range_valid),
      .beat_end_of_scan   (req_chan.end_of_scan),
      .cmd                (cmd),
      .status             (status),
      .out_valid          (rsp_chan.valid),
      .out_ready          (rsp_chan.ready),
      .out_cluster_number (rsp_chan.cluster_number),
      .out_cluster_points (rsp_chan.cluster_points),
      .out_box_min_x      (rsp_chan.box_min_x),
      .out_box_min_y      (rsp_chan.box_min_y),
      .out_box_max_x      (rsp_chan.box_max_x),
      .out_box_max_y      (rsp_chan.box_max_y),
      .out_mean_range_mm  (rsp_chan.mean_range_mm),
      .out_is_person      (rsp_chan.is_person),
      .out_scan_last      (rsp_chan.scan_last)
   );

`ifndef ASSERT_OFF
   // No beat is taken before the sine table is loaded.
   a_no_beat_in_load: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |-> status.load_done)
      else $error("beat accepted during table load");

   // A cluster is written to the output register only when that register is free.
   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == scsp_pkg::OP_EMIT) |-> status.slot_free)
      else $error("cluster emitted over a waiting response");

   // Only an open cluster is ever measured for emission.
   a_emit_open: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == scsp_pkg::OP_DIV_START) |-> status.open)
      else $error("emission started without an open cluster");

   // The divider is done by the time the box is measured.
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == scsp_pkg::OP_MUL_WX) |-> !status.div_busy)
      else $error("mean read while divider busy");
`endif

endmodule

// File: tb/sv/scan_segment_person_classifier_unit_tb.sv
`timescale 1ns / 1ps

module scan_segment_person_classifier_unit_tb;

   localparam int CNT_BITS = 12;
   localparam int SIN_DEPTH = 1024;
   localparam int CNT_MAX = (1 << CNT_BITS) - 1;
   localparam int STALL_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 120;

   typedef struct {
      logic [15:0] range_mm;
      logic        range_valid;
      logic        end_of_scan;
   } beam_type;

   typedef struct {
      logic [11:0]        cluster_number;
      logic [11:0]        cluster_points;
      logic signed [16:0] box_min_x;
      logic signed [16:0] box_min_y;
      logic signed [16:0] box_max_x;
      logic signed [16:0] box_max_y;
      logic [15:0]        mean_range_mm;
      logic               is_person;
      logic               scan_last;
   } cluster_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   scsp_req_if req_chan ();
   scsp_rsp_if rsp_chan ();

   scan_segment_person_classifier_unit uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Beams waiting to be driven and clusters waiting to come out.
   beam_type beam_queue[$];
   cluster_type cluster_q[$];
   int beams_queued = 0;
   int beams_taken = 0;
   int failures = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   logic req_took = 1'b0;
   beam_type drive_beam;

   // Predictor copy of the registers and the segmentation state.
   logic [15:0] m_angle_start;
   logic [11:0] m_angle_step;
   logic [15:0] m_gap_limit, m_near_band, m_far_band, m_min_span;
   logic [15:0] m_angle;
   bit m_fresh, m_open;
   int m_last_x, m_last_y, m_lo_x, m_lo_y, m_hi_x, m_hi_y;
   int unsigned m_points, m_total, m_clusters;
   int unsigned sine_rom[SIN_DEPTH + 1];

   // Quarter-wave sine table from an eight-term Taylor series in Q30.
   task automatic build_sine_rom();
      longint unsigned x, x2, term;
      longint sum;
      longint unsigned v;
      for (int k = 0; k <= SIN_DEPTH; k++) begin
         x = (longint'(k) * 64'd1686629713) / SIN_DEPTH;
         x2 = (x * x) >> 30;
         term = x;
         sum = x;
         for (int n = 1; n <= 7; n++) begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
         end
         if (sum < 0) sum = 0;
         v = (longint'(sum) * 65535 + (64'd1 << 29)) >> 30;
         sine_rom[k] = (v > 65535) ? 65535 : int'(v);
      end
   endtask

   function automatic int sine_of(logic [15:0] a);
      int unsigned i;
      int v;
      i = (int'(a[13:0]) * SIN_DEPTH) >> 14;
      v = a[14] ? sine_rom[SIN_DEPTH - i] : sine_rom[i];
      return a[15] ? -v : v;
   endfunction

   // Range times sine, rounded half away from zero.
   function automatic int project(int unsigned r, int c);
      longint unsigned mag;
      int v;
      mag = (c < 0) ? -c : c;
      v = int'((longint'(r) * mag + 32768) >> 16);
      return (c < 0) ? -v : v;
   endfunction

   function automatic bit looks_like_person(int unsigned mean);
      longint wx, wy, w, l2, span2;
      bit near_ok, mid_ok, far_ok;
      wx = m_hi_x - m_lo_x;
      wy = m_hi_y - m_lo_y;
      w = (wx < wy) ? wx : wy;
      l2 = wx * wx + wy * wy;
      span2 = longint'(m_min_span) * m_min_span;
      if (w == 0 || l2 > 9 * w * w || l2 < span2) return 1'b0;
      near_ok = mean <= m_near_band && m_points >= 15 && m_points <= 70 && l2 <= 490000;
      mid_ok = mean > m_near_band && mean <= m_far_band && m_points >= 10 &&
               m_points <= 35 && l2 <= 422500;
      far_ok = mean > m_far_band && m_points >= 5 && m_points <= 18 && l2 <= 490000;
      return near_ok || mid_ok || far_ok;
   endfunction

   task automatic close_cluster(bit last);
      cluster_type c;
      int unsigned mean;
      mean = m_points ? m_total / m_points : 0;
      c.cluster_number = 12'(m_clusters);
      c.cluster_points = 12'(m_points);
      c.box_min_x = 17'(m_lo_x);
      c.box_min_y = 17'(m_lo_y);
      c.box_max_x = 17'(m_hi_x);
      c.box_max_y = 17'(m_hi_y);
      c.mean_range_mm = 16'(mean);
      c.is_person = looks_like_person(mean);
      c.scan_last = last;
      cluster_q = {cluster_q, c};
      if (m_clusters < CNT_MAX) m_clusters++;
      m_open = 0;
   endtask

   task automatic start_cluster(int x, int y, int unsigned r);
      m_open = 1;
      m_points = 1;
      m_total = r;
      m_lo_x = x;
      m_hi_x = x;
      m_lo_y = y;
      m_hi_y = y;
   endtask

   // Segment one beam and queue the clusters that it closes.
   task automatic segment_beam(beam_type b);
      logic [15:0] a;
      int x, y;
      longint dx, dy;
      a = m_fresh ? m_angle_start : m_angle;
      m_fresh = 0;
      m_angle = a + 16'(m_angle_step);
      if (b.range_valid) begin
         x = project(b.range_mm, sine_of(a + scsp_pkg::QUARTER_TURN));
         y = project(b.range_mm, sine_of(a));
         if (m_open) begin
            dx = x - m_last_x;
            dy = y - m_last_y;
            if (dx * dx + dy * dy >= longint'(m_gap_limit) * m_gap_limit) begin
               close_cluster(1'b0);
               start_cluster(x, y, b.range_mm);
            end else begin
               if (m_points < CNT_MAX) begin
                  m_points++;
                  m_total += b.range_mm;
               end
               if (x < m_lo_x) m_lo_x = x;
               if (x > m_hi_x) m_hi_x = x;
               if (y < m_lo_y) m_lo_y = y;
               if (y > m_hi_y) m_hi_y = y;
            end
         end else begin
            start_cluster(x, y, b.range_mm);
         end
         m_last_x = x;
         m_last_y = y;
      end
      if (b.end_of_scan) begin
         if (m_open) close_cluster(1'b1);
         m_open = 0;
         m_clusters = 0;
         m_fresh = 1;
      end
   endtask

   // Driver: a beat is held until taken, then the next one follows or a gap.
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_took) begin
         if (beam_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            drive_beam = beam_queue.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.range_mm <= drive_beam.range_mm;
            req_chan.range_valid <= drive_beam.range_valid;
            req_chan.end_of_scan <= drive_beam.end_of_scan;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
      rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Monitor: predict on each accepted beam, check each accepted cluster.
   always @(posedge clock) begin
      cluster_type e;
      beam_type b;
      req_took <= req_chan.valid && req_chan.ready && !reset;
      if (!reset && req_chan.valid && req_chan.ready) begin
         b.range_mm = req_chan.range_mm;
         b.range_valid = req_chan.range_valid;
         b.end_of_scan = req_chan.end_of_scan;
         segment_beam(b);
         beams_taken++;
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (cluster_q.size() == 0) begin
            $error("cluster beat with nothing expected");
            failures++;
         end else begin
            e = cluster_q.pop_front();
            if (rsp_chan.cluster_number !== e.cluster_number) begin
               $error("cluster_number expected %0d actual %0d", e.cluster_number,
                      rsp_chan.cluster_number);
               failures++;
            end
            if (rsp_chan.cluster_points !== e.cluster_points) begin
               $error("cluster_points expected %0d actual %0d", e.cluster_points,
                      rsp_chan.cluster_points);
               failures++;
            end
            if (rsp_chan.box_min_x !== e.box_min_x) begin
               $error("box_min_x expected %0d actual %0d", e.box_min_x, rsp_chan.box_min_x);
               failures++;
            end
            if (rsp_chan.box_min_y !== e.box_min_y) begin
               $error("box_min_y expected %0d actual %0d", e.box_min_y, rsp_chan.box_min_y);
               failures++;
            end
            if (rsp_chan.box_max_x !== e.box_max_x) begin
               $error("box_max_x expected %0d actual %0d", e.box_max_x, rsp_chan.box_max_x);
               failures++;
            end
            if (rsp_chan.box_max_y !== e.box_max_y) begin
               $error("box_max_y expected %0d actual %0d", e.box_max_y, rsp_chan.box_max_y);
               failures++;
            end
            if (rsp_chan.mean_range_mm !== e.mean_range_mm) begin
               $error("mean_range_mm expected %0d actual %0d", e.mean_range_mm,
                      rsp_chan.mean_range_mm);
               failures++;
            end
            if (rsp_chan.is_person !== e.is_person) begin
               $error("is_person expected %0d actual %0d", e.is_person, rsp_chan.is_person);
               failures++;
            end
            if (rsp_chan.scan_last !== e.scan_last) begin
               $error("scan_last expected %0d actual %0d", e.scan_last, rsp_chan.scan_last);
               failures++;
            end
         end
      end
   end

   // Watchdog on cycles without any beat on either channel.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic add_beam(int unsigned r, bit v, bit e);
      beam_type b;
      b.range_mm = 16'(r);
      b.range_valid = v;
      b.end_of_scan = e;
      beam_queue = {beam_queue, b};
      beams_queued++;
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         scsp_pkg::CSR_ANGLE_START: m_angle_start = val;
         scsp_pkg::CSR_ANGLE_STEP: m_angle_step = val[11:0];
         scsp_pkg::CSR_GAP_LIMIT: m_gap_limit = val;
         scsp_pkg::CSR_NEAR_BAND: m_near_band = val;
         scsp_pkg::CSR_FAR_BAND: m_far_band = val;
         scsp_pkg::CSR_MIN_SPAN: m_min_span = val;
         default: ;
      endcase
   endtask

   task automatic set_regs(logic [15:0] start, logic [11:0] step, logic [15:0] gap,
                           logic [15:0] near_b, logic [15:0] far_b, logic [15:0] span);
      write_reg(scsp_pkg::CSR_ANGLE_START, start);
      write_reg(scsp_pkg::CSR_ANGLE_STEP, {4'd0, step});
      write_reg(scsp_pkg::CSR_GAP_LIMIT, gap);
      write_reg(scsp_pkg::CSR_NEAR_BAND, near_b);
      write_reg(scsp_pkg::CSR_FAR_BAND, far_b);
      write_reg(scsp_pkg::CSR_MIN_SPAN, span);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Wait until every beam is taken and every cluster is out, then let the block settle.
   task automatic drain();
      while (beams_taken != beams_queued || cluster_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // A scan of surface-like runs with jitter, jumps, dropouts and some noise.
   task automatic make_scan(int len);
      int unsigned base, r;
      base = $urandom_range(300, 15000);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < 6) base = $urandom_range(0, 20000);
         else base = (base > 40) ? base + $urandom_range(0, 60) - 30 : base + 20;
         r = ($urandom_range(99) < 5) ? $urandom_range(0, 65535) : base;
         add_beam(r[15:0], $urandom_range(99) < 90, i == len - 1);
      end
   endtask

   task automatic set_idling(int mode);
      case (mode % 4)
         0: begin send_idle_pct = 0; recv_stall_pct = 0; end
         1: begin send_idle_pct = 60; recv_stall_pct = 0; end
         2: begin send_idle_pct = 0; recv_stall_pct = 60; end
         default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
   endtask

   initial begin
      int made;
      req_chan.valid = 1'b0;
      req_chan.range_mm = '0;
      req_chan.range_valid = 1'b0;
      req_chan.end_of_scan = 1'b0;
      rsp_chan.ready = 1'b0;
      build_sine_rom();
      m_angle_start = scsp_pkg::RST_ANGLE_START;
      m_angle_step = scsp_pkg::RST_ANGLE_STEP;
      m_gap_limit = scsp_pkg::RST_GAP_LIMIT;
      m_near_band = scsp_pkg::RST_NEAR_BAND;
      m_far_band = scsp_pkg::RST_FAR_BAND;
      m_min_span = scsp_pkg::RST_MIN_SPAN;
      m_angle = '0;
      m_fresh = 1;
      m_open = 0;
      m_last_x = 0; m_last_y = 0;
      m_points = 0; m_total = 0; m_clusters = 0;
      m_lo_x = 0; m_lo_y = 0; m_hi_x = 0; m_hi_y = 0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed beams at reset settings: end of scan with nothing open, range
      // extremes, a dropout inside a cluster, a split that also ends the scan.
      add_beam(16'd0, 1'b0, 1'b1);
      add_beam(16'd0, 1'b1, 1'b0);
      add_beam(16'd65535, 1'b1, 1'b0);
      add_beam(16'd65535, 1'b0, 1'b0);
      add_beam(16'd65535, 1'b1, 1'b1);
      add_beam(16'd1000, 1'b1, 1'b0);
      add_beam(16'd1005, 1'b0, 1'b0);
      add_beam(16'd1010, 1'b1, 1'b0);
      add_beam(16'd5000, 1'b1, 1'b1);
      drain();

      // Clusters in all three bands with fine beam spacing.
      set_regs(16'h0000, 12'd40, 16'd100, 16'd5000, 16'd10000, 16'd250);
      for (int i = 0; i < 20; i++) add_beam(16'd3000 + i, 1'b1, 1'b0);
      for (int i = 0; i < 12; i++) add_beam(16'd7000 - 10 * i, 1'b1, 1'b0);
      add_beam(16'd12000, 1'b1, 1'b0);
      add_beam(16'd12010, 1'b1, 1'b1);
      drain();

      // Random phases with varied and extreme register settings.
      for (int p = 0; p < 12; p++) begin
         case (p)
            0: set_regs(16'h8000, 12'd0, 16'd0, 16'd0, 16'd0, 16'd0);
            1: set_regs(16'h7FFF, 12'd4095, 16'd65535, 16'd65535, 16'd65535, 16'd65535);
            2: set_regs(16'h0000, 12'd60, 16'd100, 16'd12000, 16'd4000, 16'd100);
            3: set_regs(16'hC000, 12'd30, 16'd150, 16'd5000, 16'd10000, 16'd200);
            default: set_regs(16'($urandom_range(0, 65535)), 12'($urandom_range(0, 200)),
                              16'($urandom_range(20, 400)), 16'($urandom_range(0, 20000)),
                              16'($urandom_range(0, 20000)), 16'($urandom_range(0, 500)));
         endcase
         set_idling(p);
         made = beams_queued;
         while (beams_queued - made < 75) make_scan($urandom_range(5, 60));
         drain();
      end
      set_idling(0);

      if (failures == 0 && cluster_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
